@@ design/set_assoc_lru_cache_sim_top_macros.svh @@
// Assertion helpers for the cache checker.
`ifndef SET_ASSOC_LRU_CACHE_SIM_TOP_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SALC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cache check failed");

// Next-cycle implication, disabled while in reset.
`define SALC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cache check failed");

`endif

@@ design/salc_pkg.sv @@
package salc_pkg;

  localparam int MAX_SETS = 1024;
  localparam int MAX_WAYS = 8;
  localparam int SET_W    = $clog2(MAX_SETS);
  localparam int WAY_CW   = 4;
  localparam int TAG_W    = 64;
  localparam int AGE_W    = 3;
  localparam int LINE_W   = TAG_W + AGE_W + 1;
  localparam int ROW_W    = LINE_W * MAX_WAYS;

  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  localparam logic [1:0] REQ_MODIFY = 2'd2;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  typedef struct packed {
    logic clr;
    logic accept;
    logic look;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } stat_t;

endpackage

@@ design/salc_ram.sv @@
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/salc_ctrl.sv @@
module salc_ctrl import salc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_LOOK = 2'd2;

  logic [1:0] state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_CLR:   if (stat.clr_last) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_LOOK;
      S_LOOK:  state_next = S_IDLE;
      default: state_next = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign busy       = (state != S_IDLE);
  assign cmd.clr    = (state == S_CLR);
  assign cmd.accept = (state == S_IDLE) && start;
  assign cmd.look   = (state == S_LOOK);

endmodule

@@ design/salc_dpath.sv @@
module salc_dpath import salc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [3:0]  set_bits,
  input  logic [5:0]  block_bits,
  input  logic [3:0]  ways,
  input  logic [1:0]  req_type,
  input  logic [63:0] address,
  output logic        done,
  output logic [1:0]  outcome,
  output logic        second_hit,
  output logic [31:0] hit_count,
  output logic [31:0] miss_count,
  output logic [31:0] eviction_count
);

  logic [SET_W-1:0] clr_cnt;
  logic [SET_W-1:0] in_set, set_r;
  logic [TAG_W-1:0] in_tag, tag_r;
  logic [1:0]       req_r;
  logic [ROW_W-1:0] rdata, new_row, wdata;
  logic [SET_W-1:0] waddr;
  logic             we;

  // address split
  logic [3:0]       sb;
  logic [6:0]       tsh;
  logic [63:0]      shifted;
  logic [SET_W-1:0] mask;

  always_comb begin
    sb = (set_bits > 4'(SET_W)) ? 4'(SET_W) : set_bits;
    shifted = address >> block_bits;
    for (int i = 0; i < SET_W; i++) begin
      mask[i] = (i < int'(sb));
    end
    in_set = shifted[SET_W-1:0] & mask;
    tsh = 7'(block_bits) + 7'(sb);
    in_tag = tsh[6] ? '0 : (address >> tsh[5:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      set_r <= in_set;
      tag_r <= in_tag;
      req_r <= req_type;
    end
  end

  // lookup and rank update
  logic [WAY_CW-1:0] nw;
  logic [MAX_WAYS-1:0] act, vld, hitv;
  logic [AGE_W-1:0]  age [MAX_WAYS];
  logic [TAG_W-1:0]  tg  [MAX_WAYS];
  logic              hit_f, emp_f, vic_f;
  logic [WAY_CW-1:0] hit_w, emp_w, vic_w, tgt;
  logic [AGE_W:0]    rank;
  logic [1:0]        oc;

  always_comb begin
    nw = (ways == '0) ? 4'd1 : ((ways > 4'(MAX_WAYS)) ? 4'(MAX_WAYS) : ways);
    hit_f = 1'b0; emp_f = 1'b0; vic_f = 1'b0;
    hit_w = '0; emp_w = '0; vic_w = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      tg[w]   = rdata[w*LINE_W +: TAG_W];
      age[w]  = rdata[w*LINE_W + TAG_W +: AGE_W];
      vld[w]  = rdata[w*LINE_W + TAG_W + AGE_W];
      act[w]  = (w < int'(nw));
      hitv[w] = act[w] && vld[w] && (tg[w] == tag_r);
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (act[w] && !vld[w] && !emp_f) begin
        emp_f = 1'b1; emp_w = 4'(w);
      end
      if (hitv[w] && !hit_f) begin
        hit_f = 1'b1; hit_w = 4'(w);
      end
      if (act[w] && vld[w] && (!vic_f || age[w] > age[vic_w[2:0]])) begin
        vic_f = 1'b1; vic_w = 4'(w);
      end
    end
    if (hit_f) begin
      tgt = hit_w; oc = OUT_HIT; rank = {1'b0, age[hit_w[2:0]]};
    end else if (emp_f) begin
      tgt = emp_w; oc = OUT_FILL; rank = 4'(MAX_WAYS);
    end else begin
      tgt = vic_w; oc = OUT_EVICT; rank = {1'b0, age[vic_w[2:0]]};
    end
    new_row = rdata;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (4'(w) == tgt) begin
        new_row[w*LINE_W +: LINE_W] = {1'b1, {AGE_W{1'b0}}, tag_r};
      end else if (act[w] && vld[w] && ({1'b0, age[w]} < rank)
                   && (age[w] != {AGE_W{1'b1}})) begin
        new_row[w*LINE_W + TAG_W +: AGE_W] = age[w] + 1'b1;
      end
    end
  end

  assign we    = cmd.clr || cmd.look;
  assign waddr = cmd.clr ? clr_cnt : set_r;
  assign wdata = cmd.clr ? '0 : new_row;

  salc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.accept),
    .raddr (in_set),
    .rdata (rdata)
  );

  assign stat.clr_last = (clr_cnt == SET_W'(MAX_SETS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // totals
  logic [31:0] h1, h2;
  always_comb begin
    h1 = (oc == OUT_HIT && hit_count != '1) ? hit_count + 1'b1 : hit_count;
    h2 = (req_r == REQ_MODIFY && h1 != '1) ? h1 + 1'b1 : h1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done           <= 1'b0;
      hit_count      <= '0;
      miss_count     <= '0;
      eviction_count <= '0;
    end else begin
      done <= cmd.look;
      if (cmd.look) begin
        hit_count <= h2;
        if (oc != OUT_HIT && miss_count != '1) begin
          miss_count <= miss_count + 1'b1;
        end
        if (oc == OUT_EVICT && eviction_count != '1) begin
          eviction_count <= eviction_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      outcome    <= oc;
      second_hit <= (req_r == REQ_MODIFY);
    end
  end

endmodule

@@ design/set_assoc_lru_cache_sim_top.sv @@
// Set-associative cache simulator with true LRU ranks.
// Request channel: drive req_type and address with start; the request is
// taken at a rising edge with start high and busy low.
// Result channel: done is high for exactly one cycle with outcome,
// second_hit and the three saturating totals; the receiver cannot stall,
// and the totals stay on their ports until the next result.
// Sequence: done is registered from the lookup state, and busy is high
// for one cycle after each request, so no new request is taken during a
// lookup. The cost is one memory row read per set (all ways in one wide
// row), then the parallel tag compare and the rank and line write-back
// in the following cycle.
// Reset: rst (synchronous) clears totals and control, then a clearing pass
// writes every set row of the line memory to invalid, one row a cycle, for
// 1024 rows with busy held high. Configuration writes are taken meanwhile.
// Config: APB at byte addresses 0 set_bits, 4 block_bits, 8 ways; pready
// is always high and reads return the register value.
module set_assoc_lru_cache_sim_top import salc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [63:0] address,
  output logic        done,
  output logic [1:0]  outcome,
  output logic        second_hit,
  output logic [31:0] hit_count,
  output logic [31:0] miss_count,
  output logic [31:0] eviction_count
);

  logic [3:0] set_bits;
  logic [5:0] block_bits;
  logic [3:0] ways;
  logic [1:0] reg_idx;
  cmd_t       cmd;
  stat_t      stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  // config registers; writes to the unused address are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= 4'd4;
      block_bits <= 6'd4;
      ways       <= 4'd1;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_SET_BITS:   set_bits   <= pwdata[3:0];
        REG_BLOCK_BITS: block_bits <= pwdata[5:0];
        REG_WAYS:       ways       <= pwdata[3:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SET_BITS:   prdata = {28'd0, set_bits};
      REG_BLOCK_BITS: prdata = {26'd0, block_bits};
      REG_WAYS:       prdata = {28'd0, ways};
      default:        prdata = '0;
    endcase
  end

  salc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  salc_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .set_bits       (set_bits),
    .block_bits     (block_bits),
    .ways           (ways),
    .req_type       (req_type),
    .address        (address),
    .done           (done),
    .outcome        (outcome),
    .second_hit     (second_hit),
    .hit_count      (hit_count),
    .miss_count     (miss_count),
    .eviction_count (eviction_count)
  );

endmodule

@@ design/salc_checker.sv @@
`include "set_assoc_lru_cache_sim_top_macros.svh"

module salc_props (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] outcome
);

  `SALC_ASSERT_NXT(a_busy_after_req, start && !busy, busy)
  `SALC_ASSERT_NXT(a_done_two_after, start && !busy, ##1 done)
  `SALC_ASSERT_IMP(a_outcome_code, done, outcome != 2'd3)
  `SALC_ASSERT_NXT(a_done_single, done, !done)

endmodule

bind set_assoc_lru_cache_sim_top salc_props u_salc_props (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .outcome (outcome)
);

@@ dv/salc_checker.sv @@
module salc_checker import salc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  req_type,
  input  logic [63:0] address,
  input  logic        done,
  input  logic [1:0]  outcome,
  input  logic        second_hit,
  input  logic [31:0] hit_count,
  input  logic [31:0] miss_count,
  input  logic [31:0] eviction_count,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  outcome;
    logic        second_hit;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evicts;
  } access_result_t;

  access_result_t expected_q[$];

  logic        valid_m [MAX_SETS][MAX_WAYS];
  logic [63:0] tag_m   [MAX_SETS][MAX_WAYS];
  int          rank_m  [MAX_SETS][MAX_WAYS];
  logic [31:0] hits_r, misses_r, evicts_r;
  logic [3:0]  set_bits_r, ways_r;
  logic [5:0]  block_bits_r;

  assign pending = expected_q.size();

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // true LRU with ranks, 0 = most recent
  function automatic access_result_t cache_access(logic [1:0] kind, logic [63:0] addr);
    int sb, nw, set_i, hit_w, empty_w, victim_w, r;
    logic [63:0] idx, tag;
    access_result_t res;
    sb = (set_bits_r > SET_W) ? SET_W : set_bits_r;
    nw = (ways_r < 1) ? 1 : (ways_r > MAX_WAYS) ? MAX_WAYS : ways_r;
    idx = (addr >> block_bits_r) & ((64'd1 << sb) - 64'd1);
    set_i = int'(idx);
    tag = (block_bits_r + sb >= 64) ? 64'd0 : addr >> (block_bits_r + sb);
    hit_w = -1; empty_w = -1; victim_w = -1;
    for (int w = 0; w < nw; w++) begin
      if (!valid_m[set_i][w]) begin
        if (empty_w < 0) empty_w = w;
        continue;
      end
      if (hit_w < 0 && tag_m[set_i][w] == tag) hit_w = w;
      if (victim_w < 0 || rank_m[set_i][w] > rank_m[set_i][victim_w]) victim_w = w;
    end
    if (hit_w >= 0 || empty_w < 0) begin
      // hit or eviction: lines newer than the touched one age by one
      int tw;
      tw = (hit_w >= 0) ? hit_w : victim_w;
      r = rank_m[set_i][tw];
      for (int w = 0; w < nw; w++)
        if (valid_m[set_i][w] && w != tw && rank_m[set_i][w] < r)
          rank_m[set_i][w]++;
      rank_m[set_i][tw] = 0;
      tag_m[set_i][tw] = tag;
      if (hit_w >= 0) begin
        hits_r = sat_inc(hits_r);
        res.outcome = OUT_HIT;
      end else begin
        misses_r = sat_inc(misses_r);
        evicts_r = sat_inc(evicts_r);
        res.outcome = OUT_EVICT;
      end
    end else begin
      for (int w = 0; w < nw; w++)
        if (valid_m[set_i][w]) rank_m[set_i][w]++;
      valid_m[set_i][empty_w] = 1'b1;
      tag_m[set_i][empty_w] = tag;
      rank_m[set_i][empty_w] = 0;
      misses_r = sat_inc(misses_r);
      res.outcome = OUT_FILL;
    end
    if (kind == REQ_MODIFY) hits_r = sat_inc(hits_r);
    res.second_hit = (kind == REQ_MODIFY);
    res.hits = hits_r;
    res.misses = misses_r;
    res.evicts = evicts_r;
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    access_result_t want;
    if (rst) begin
      foreach (valid_m[s, w]) valid_m[s][w] = 1'b0;
      hits_r = '0; misses_r = '0; evicts_r = '0;
      set_bits_r = 4'd4; block_bits_r = 6'd4; ways_r = 4'd1;
      expected_q.delete();
      errors = 0;
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 32'd0, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (outcome !== want.outcome)
            report("outcome", 32'(outcome), 32'(want.outcome));
          if (second_hit !== want.second_hit)
            report("second_hit", 32'(second_hit), 32'(want.second_hit));
          if (hit_count !== want.hits) report("hit_count", hit_count, want.hits);
          if (miss_count !== want.misses) report("miss_count", miss_count, want.misses);
          if (eviction_count !== want.evicts)
            report("eviction_count", eviction_count, want.evicts);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SET_BITS:   set_bits_r = pwdata[3:0];
          REG_BLOCK_BITS: block_bits_r = pwdata[5:0];
          REG_WAYS:       ways_r = pwdata[3:0];
          default: ;
        endcase
      end
      if (start && !busy) expected_q.push_back(cache_access(req_type, address));
    end
  end
endmodule

@@ dv/tb_top.sv @@
module tb_top import salc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_STORE = 2'd1;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = '0;
  logic [63:0] address = '0;
  logic        done;
  logic [1:0]  outcome;
  logic        second_hit;
  logic [31:0] hit_count, miss_count, eviction_count;
  int          errors, pending;
  int          cycles = 0;

  // current configuration, used only to shape addresses
  int          cur_sb = 4, cur_bb = 4;
  logic [63:0] addr_pool[16];

  set_assoc_lru_cache_sim_top dut (.*);

  salc_checker chk (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // APB write: setup cycle then access cycle, pready is always high
  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // drains outstanding requests before touching config
  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(int sb, int bb, int nw);
    wait_idle();
    reg_write(REG_SET_BITS, sb);
    reg_write(REG_BLOCK_BITS, bb);
    reg_write(REG_WAYS, nw);
    cur_sb = (sb > SET_W) ? SET_W : sb;
    cur_bb = bb;
  endtask

  // mostly back to back, some short gaps, a few long ones
  task automatic idle_gap();
    int n, pick;
    pick = $urandom_range(99);
    if (pick < 55) n = 0;
    else if (pick < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 30);
    if (n > 0) begin
      start = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // one request; returns at the falling edge after it was taken
  task automatic send(logic [1:0] kind, logic [63:0] addr);
    idle_gap();
    start = 1'b1; req_type = kind; address = addr;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // pool with many addresses sharing one set, so hits and evictions happen
  task automatic build_pool();
    logic [63:0] set_mask;
    set_mask = (cur_bb >= 64) ? 64'd0 :
               (((64'd1 << cur_sb) - 64'd1) << cur_bb);
    foreach (addr_pool[i]) begin
      addr_pool[i] = rand64();
      if (i < 10) addr_pool[i] = (addr_pool[i] & ~set_mask) | (addr_pool[0] & set_mask);
      if (i % 3 == 1) addr_pool[i] = addr_pool[i] & 64'hFFFF;  // small tags too
    end
  endtask

  task automatic random_phase(int count);
    int pick;
    logic [63:0] a;
    logic [1:0] kind;
    build_pool();
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      a = addr_pool[$urandom_range(15)];
      if (pick < 60) a = a ^ ($urandom & ((cur_bb >= 32) ? 32'hFFFF_FFFF : (32'd1 << cur_bb) - 1));
      else if (pick < 85) a = rand64();
      else a = a ^ (64'd1 << $urandom_range(63));
      kind = 2'($urandom_range(3));
      send(kind, a);
    end
    start = 1'b0;
  endtask

  initial begin
    int sb, bb, nw;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed: default config, one way per set
    send(REQ_LOAD, 64'd0);                       // fill empty way
    send(REQ_LOAD, 64'd0);                       // hit
    send(REQ_STORE, 64'd5);                      // same line, other offset
    send(REQ_MODIFY, 64'd0);                     // hit plus store hit
    send(REQ_UNKNOWN, 64'h100);                  // unknown kind acts as load
    send(REQ_MODIFY, 64'h200);                   // same set, other tag: evict
    send(REQ_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
    send(REQ_STORE, 64'hFFFF_FFFF_FFFF_FFF0);
    send(REQ_LOAD, 64'h8000_0000_0000_0000);
    send(REQ_MODIFY, 64'h5555_5555_5555_5555);
    send(REQ_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
    start = 1'b0;

    // four ways, fill a set then walk the LRU order
    configure(2, 4, 4);
    for (int i = 0; i < 6; i++) send(REQ_LOAD, 64'(i) << 6);
    send(REQ_LOAD, 64'h40);
    send(REQ_LOAD, 64'h0);
    send(REQ_MODIFY, 64'h200);
    start = 1'b0;

    // lowered ways hide lines, raising ways shows them again
    configure(2, 4, 1);
    send(REQ_LOAD, 64'h100);
    send(REQ_LOAD, 64'h40);
    start = 1'b0;
    configure(2, 4, 4);
    send(REQ_LOAD, 64'h100);
    send(REQ_LOAD, 64'h140);
    start = 1'b0;

    // extremes and corners, then random configs
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin sb = 0;  bb = 1;  nw = 8;  end   // single set
        1: begin sb = 15; bb = 63; nw = 15; end   // clamps, shift past address
        2: begin sb = 10; bb = 54; nw = 0;  end   // tag shifted away
        3: begin sb = 10; bb = 32; nw = 8;  end
        4: begin sb = 1;  bb = 0;  nw = 2;  end
        5: begin sb = 1;  bb = 1;  nw = 1;  end
        6: begin sb = 12; bb = 2;  nw = 9;  end
        default: begin
          sb = $urandom_range(15); bb = $urandom_range(63); nw = $urandom_range(15);
        end
      endcase
      configure(sb, bb, nw);
      random_phase(58);
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+design
design/salc_pkg.sv
design/salc_ram.sv
design/salc_ctrl.sv
design/salc_dpath.sv
design/set_assoc_lru_cache_sim_top.sv
design/salc_checker.sv
dv/salc_checker.sv
dv/tb_top.sv
